[hdl/scts_pkg.sv]
// Shared types and constants for the signed-choice target-sum counter.
package scts_pkg;

    localparam int MAX_ELEMENTS = 20;
    localparam int VALUE_BITS   = 32;

    // Fixed field widths
    localparam int INDEX_W     = 5;
    localparam int ELEM_CNT_W  = 5;
    localparam int TARGET_W    = 37;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 1;

    // Derived widths
    localparam int IDX_W      = $clog2(MAX_ELEMENTS);
    localparam int K_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W      = VALUE_BITS + K_W;
    localparam int CMP_W      = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;
    localparam int IN_DATA_W  = ((INDEX_W + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COUNT_W + 7) / 8) * 8;
    localparam int CFG_DATA_W = (ELEM_CNT_W > TARGET_W) ? ELEM_CNT_W : TARGET_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEMENT_COUNT = 1'b0,
        CFG_TARGET_SUM    = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_RUN  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK
    } t_state;

    typedef logic [1:0] t_digit;

endpackage

[hdl/signed_choice_target_sum_count.sv]
// Sequence: load items are accepted back to back while idle. A run item first forms
// the all-minus starting sum over element_count stored values, switches over to
// the walk, then steps once per combination, 3^element_count in all; the result is
// registered at the end of the last combination step, and the next item can be
// accepted in the following cycle. The one 37-bit add/subtract unit and its sum
// register serve every step. The last combination step also waits while an earlier
// result is still unread. Combinations are walked in reflected ternary Gray
// order, so each step moves one digit by one and costs a single add or subtract
// of one stored value. The input side is not ready during a run; loads are
// accepted while a previous result still waits on the output. Values must be
// loaded for every index a run uses.
module signed_choice_target_sum_count (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [scts_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // index[4:0], value[36:5]
    input  logic                              s_axis_tuser,  // func
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [scts_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // match_count[31:0], total_count[63:32]
);

    localparam int MAXE = scts_pkg::MAX_ELEMENTS;
    localparam int VB   = scts_pkg::VALUE_BITS;

    scts_pkg::t_state r_state, n_state;

    logic [scts_pkg::ELEM_CNT_W-1:0]        r_elem_cfg;
    logic signed [scts_pkg::TARGET_W-1:0]   r_target;

    logic [VB-1:0]                          r_value [MAXE];

    logic [scts_pkg::K_W-1:0]               r_k, n_k;
    logic [scts_pkg::K_W-1:0]               r_idx, n_idx;
    logic signed [scts_pkg::SUM_W-1:0]      r_sum, n_sum;
    logic [MAXE-1:0][1:0]                   r_digit, n_digit;
    logic [MAXE-1:0]                        r_dir, n_dir;     // 1: digit moving down
    logic [scts_pkg::COUNT_W-1:0]           r_match, n_match;
    logic [scts_pkg::COUNT_W-1:0]           r_total, n_total;
    logic                                   r_out_valid, n_out_valid;
    logic [scts_pkg::COUNT_W-1:0]           r_out_match, n_out_match;
    logic [scts_pkg::COUNT_W-1:0]           r_out_total, n_out_total;

    logic                                   in_xfer, out_xfer;
    scts_pkg::t_func                        in_func;
    logic [scts_pkg::INDEX_W-1:0]           in_index;
    logic [VB-1:0]                          in_value;

    logic                                   found;
    logic [scts_pkg::IDX_W-1:0]             sel;
    logic [scts_pkg::IDX_W-1:0]             rd_addr;
    logic signed [scts_pkg::SUM_W-1:0]      operand;
    logic                                   do_sub;
    logic signed [scts_pkg::SUM_W-1:0]      alu_out;
    logic                                   hit;
    logic                                   init_done;
    logic                                   finish_ok;

    assign in_func  = scts_pkg::t_func'(s_axis_tuser);
    assign in_index = s_axis_tdata[scts_pkg::INDEX_W-1:0];
    assign in_value = s_axis_tdata[scts_pkg::INDEX_W +: VB];

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = r_out_valid && m_axis_tready;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(scts_pkg::OUT_DATA_W - 2 * scts_pkg::COUNT_W){1'b0}},
                            r_out_total, r_out_match};

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cfg <= '0;
            r_target   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (scts_pkg::t_cfg_reg'(i_cfg_index))
                scts_pkg::CFG_ELEMENT_COUNT: begin
                    r_elem_cfg <= i_cfg_data[scts_pkg::ELEM_CNT_W-1:0];
                end
                scts_pkg::CFG_TARGET_SUM: begin
                    r_target <= $signed(i_cfg_data[scts_pkg::TARGET_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Value store, written by load transfers
    always_ff @(posedge i_clk) begin
        if (in_xfer && in_func == scts_pkg::FUNC_LOAD &&
            in_index < scts_pkg::INDEX_W'(MAXE)) begin
            r_value[in_index[scts_pkg::IDX_W-1:0]] <= in_value;
        end
    end

    // Lowest digit able to step in its current direction
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < MAXE; i++) begin
            if (!found && scts_pkg::K_W'(i) < r_k &&
                (r_dir[i] ? (r_digit[i] != 2'd0) : (r_digit[i] != 2'd2))) begin
                found = 1'b1;
                sel   = scts_pkg::IDX_W'(i);
            end
        end
    end

    // Shared add/subtract unit
    assign rd_addr   = (r_state == scts_pkg::ST_INIT) ? r_idx[scts_pkg::IDX_W-1:0] : sel;
    assign operand   = scts_pkg::SUM_W'($signed(r_value[rd_addr]));
    assign do_sub    = (r_state == scts_pkg::ST_INIT) ? 1'b1 : r_dir[sel];
    assign alu_out   = do_sub ? (r_sum - operand) : (r_sum + operand);

    assign hit       = (scts_pkg::CMP_W'(r_sum) == scts_pkg::CMP_W'(r_target));
    assign init_done = (r_idx == r_k);
    assign finish_ok = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scts_pkg::ST_IDLE: begin
                if (in_xfer && in_func == scts_pkg::FUNC_RUN) begin
                    n_state = scts_pkg::ST_INIT;
                end
            end
            scts_pkg::ST_INIT: begin
                if (init_done) begin
                    n_state = scts_pkg::ST_WALK;
                end
            end
            scts_pkg::ST_WALK: begin
                if (!found && finish_ok) begin
                    n_state = scts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        s_axis_tready = (r_state == scts_pkg::ST_IDLE);
        n_k         = r_k;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_digit     = r_digit;
        n_dir       = r_dir;
        n_match     = r_match;
        n_total     = r_total;
        n_out_valid = out_xfer ? 1'b0 : r_out_valid;
        n_out_match = r_out_match;
        n_out_total = r_out_total;

        unique case (r_state)
            scts_pkg::ST_IDLE: begin
                if (in_xfer && in_func == scts_pkg::FUNC_RUN) begin
                    n_k     = (r_elem_cfg > scts_pkg::ELEM_CNT_W'(MAXE)) ?
                              scts_pkg::K_W'(MAXE) : scts_pkg::K_W'(r_elem_cfg);
                    n_idx   = '0;
                    n_sum   = '0;
                    n_digit = '0;
                    n_dir   = '0;
                    n_match = '0;
                    n_total = scts_pkg::COUNT_W'(1);
                end
            end
            scts_pkg::ST_INIT: begin
                // all digits start at minus
                if (!init_done) begin
                    n_sum   = alu_out;
                    n_idx   = r_idx + scts_pkg::K_W'(1);
                    n_total = r_total + {r_total[scts_pkg::COUNT_W-2:0], 1'b0};
                end
            end
            scts_pkg::ST_WALK: begin
                if (found) begin
                    n_match = r_match + scts_pkg::COUNT_W'(hit);
                    n_sum   = alu_out;
                    n_digit[sel] = r_dir[sel] ? (r_digit[sel] - 2'd1)
                                              : (r_digit[sel] + 2'd1);
                    // digits below the moving one sit at an end: reflect them
                    for (int i = 0; i < MAXE; i++) begin
                        if (scts_pkg::IDX_W'(i) < sel) begin
                            n_dir[i] = ~r_dir[i];
                        end
                    end
                end else if (finish_ok) begin
                    n_out_valid = 1'b1;
                    n_out_match = r_match + scts_pkg::COUNT_W'(hit);
                    n_out_total = r_total;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scts_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_digit     <= '0;
            r_dir       <= '0;
            r_match     <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_idx       <= n_idx;
            r_sum       <= n_sum;
            r_digit     <= n_digit;
            r_dir       <= n_dir;
            r_match     <= n_match;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_match <= n_out_match;
        r_out_total <= n_out_total;
    end

endmodule
